FILE: rtl/mdsr_pkg.sv
// ----------------------------------------------------------------------------
// mdsr_pkg: shared types and constants for the motor duty step ramp
// Request/result transaction structs, register map codes, duty limits.
// ----------------------------------------------------------------------------
package mdsr_pkg;

    // Duty ceiling used for the percent compare value (per mille)
    localparam int unsigned DUTY_MAX   = 1000;
    // Highest speed step a request may select
    localparam int unsigned STEP_COUNT = 4;

    // Rounding offset and divisor for per mille to percent
    localparam int unsigned PCT_ROUND  = 5;
    localparam int unsigned PCT_DIV    = 10;

    // APB address width: eight 32-bit registers at 4*i
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;

    // Request codes
    typedef enum logic [1:0] {
        REQ_SET_STEP = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_STOP     = 2'd2,
        REQ_NONE     = 2'd3
    } req_code_t;

    // Register indexes
    typedef enum logic [2:0] {
        REG_LEVEL_ONE   = 3'd0,
        REG_LEVEL_TWO   = 3'd1,
        REG_LEVEL_THREE = 3'd2,
        REG_LEVEL_FOUR  = 3'd3,
        REG_KICK        = 3'd4,
        REG_INTERVAL    = 3'd5,
        REG_INCREMENT   = 3'd6,
        REG_FREQUENCY   = 3'd7
    } reg_idx_t;

    // Request transaction
    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [7:0] step_request;
        logic [31:0]       now_ms;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic        enabled;
        logic [2:0]  step_now;
        logic [9:0]  duty_now;
        logic [19:0] freq_report;
        logic [6:0]  pwm_percent;
        logic        output_active;
    } rsp_t;

    // Configuration bundle from the register file to the core
    typedef struct packed {
        logic [9:0]  level_one_duty;
        logic [9:0]  level_two_duty;
        logic [9:0]  level_three_duty;
        logic [9:0]  level_four_duty;
        logic [9:0]  kick_duty;
        logic [15:0] ramp_interval;
        logic [9:0]  ramp_increment;
        logic [19:0] pwm_frequency;
    } cfg_t;

endpackage

FILE: rtl/motor_duty_step_ramp.sv
// ----------------------------------------------------------------------------
// motor_duty_step_ramp: PWM duty slew limiter with kickstart
// Set-step, tick and stop requests drive a ramped duty; APB configuration.
//
//   channel  direction  payload           handshake
//   req      in         mdsr_pkg::req_t   req_valid / req_stall
//   rsp      out        mdsr_pkg::rsp_t   rsp_valid / rsp_stall
//   apb      in/out     32-bit registers  psel / penable, pready tied high
//
// One request per cycle unless req_stall is high; a result is taken
// through the input register, then the result register.
// Set step and stop always return a result; a tick returns one only when
// ramping is on and the interval has elapsed; request code 3 is dropped.
// Reset clears the duty state and loads register defaults.
// A stalled result holds; the input register keeps accepting while the
// result register is empty or being taken.
// ----------------------------------------------------------------------------
module motor_duty_step_ramp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  mdsr_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output mdsr_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdsr_pkg::ADDR_W-1:0] paddr,
    input  logic [mdsr_pkg::DATA_W-1:0] pwdata,
    output logic [mdsr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    mdsr_pkg::cfg_t cfg;

    // Configuration registers
    mdsr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request processing
    mdsr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/mdsr_regs.sv
// ----------------------------------------------------------------------------
// mdsr_regs: APB configuration registers
// Eight registers at byte offsets 4*i, written on the access phase.
// ----------------------------------------------------------------------------
module mdsr_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mdsr_pkg::ADDR_W-1:0]       paddr,
    input  logic [mdsr_pkg::DATA_W-1:0]       pwdata,
    output logic [mdsr_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    output mdsr_pkg::cfg_t                    cfg
);

    mdsr_pkg::cfg_t     cfg_reg;
    mdsr_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = mdsr_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_one_duty   <= 10'd250;
            cfg_reg.level_two_duty   <= 10'd500;
            cfg_reg.level_three_duty <= 10'd750;
            cfg_reg.level_four_duty  <= 10'd1000;
            cfg_reg.kick_duty        <= 10'd350;
            cfg_reg.ramp_interval    <= 16'd20;
            cfg_reg.ramp_increment   <= 10'd10;
            cfg_reg.pwm_frequency    <= 20'd20000;
        end
        else if (wr_en)
        begin
            case (idx)
                mdsr_pkg::REG_LEVEL_ONE:   cfg_reg.level_one_duty   <= pwdata[9:0];
                mdsr_pkg::REG_LEVEL_TWO:   cfg_reg.level_two_duty   <= pwdata[9:0];
                mdsr_pkg::REG_LEVEL_THREE: cfg_reg.level_three_duty <= pwdata[9:0];
                mdsr_pkg::REG_LEVEL_FOUR:  cfg_reg.level_four_duty  <= pwdata[9:0];
                mdsr_pkg::REG_KICK:        cfg_reg.kick_duty        <= pwdata[9:0];
                mdsr_pkg::REG_INTERVAL:    cfg_reg.ramp_interval    <= pwdata[15:0];
                mdsr_pkg::REG_INCREMENT:   cfg_reg.ramp_increment   <= pwdata[9:0];
                mdsr_pkg::REG_FREQUENCY:   cfg_reg.pwm_frequency    <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            mdsr_pkg::REG_LEVEL_ONE:   prdata = 32'(cfg_reg.level_one_duty);
            mdsr_pkg::REG_LEVEL_TWO:   prdata = 32'(cfg_reg.level_two_duty);
            mdsr_pkg::REG_LEVEL_THREE: prdata = 32'(cfg_reg.level_three_duty);
            mdsr_pkg::REG_LEVEL_FOUR:  prdata = 32'(cfg_reg.level_four_duty);
            mdsr_pkg::REG_KICK:        prdata = 32'(cfg_reg.kick_duty);
            mdsr_pkg::REG_INTERVAL:    prdata = 32'(cfg_reg.ramp_interval);
            mdsr_pkg::REG_INCREMENT:   prdata = 32'(cfg_reg.ramp_increment);
            mdsr_pkg::REG_FREQUENCY:   prdata = 32'(cfg_reg.pwm_frequency);
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: rtl/mdsr_core.sv
// ----------------------------------------------------------------------------
// mdsr_core: request register, duty state update and result register
// One request per cycle unless stalled; state is updated as a request leaves the input stage.
// ----------------------------------------------------------------------------
module mdsr_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  mdsr_pkg::cfg_t cfg,
    input  logic           req_valid,
    output logic           req_stall,
    input  mdsr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mdsr_pkg::rsp_t rsp
);

    // x/10 as (x*205)>>11, exact for x below 1024; the remainder check only
    // ever raises the quotient
    localparam logic [7:0]  RECIP10   = 8'd205;
    localparam logic [11:0] DIV_C     = 12'(mdsr_pkg::PCT_DIV);
    localparam logic [10:0] ROUND_C   = 11'(mdsr_pkg::PCT_ROUND);
    localparam logic [9:0]  DUTY_CAP  = 10'(mdsr_pkg::DUTY_MAX);
    localparam logic [2:0]  STEP_TOP  = 3'(mdsr_pkg::STEP_COUNT);

    // Input stage
    logic           s1_valid_reg, s1_valid_next;
    mdsr_pkg::req_t s1_reg;

    // Result stage
    logic           rsp_valid_reg, rsp_valid_next;
    mdsr_pkg::rsp_t rsp_reg, rsp_next;

    // Duty state
    logic [9:0]  duty_reg, duty_next;
    logic [9:0]  goal_duty_reg, goal_duty_next;
    logic [2:0]  goal_step_reg, goal_step_next;
    logic        ramp_on_reg, ramp_on_next;
    logic [31:0] last_time_reg, last_time_next;
    logic        live_reg, live_next;

    logic        out_free;
    logic        advance;
    logic        emit;
    logic        live_emit;

    logic [2:0]  clamp_step;
    logic [9:0]  level_sel;
    logic [31:0] elapsed;
    logic        due;
    logic [10:0] up_sum;
    logic [9:0]  up_val;
    logic [9:0]  down_amt;
    logic [9:0]  down_diff;
    logic [9:0]  down_val;
    logic [9:0]  ramp_val;
    logic [9:0]  pct_duty;
    logic [10:0] pct_in;
    logic [18:0] pct_prod;
    logic [7:0]  pct_quo;
    logic [11:0] pct_rem;
    logic [7:0]  pct_fix;

    // Handshake
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Step clamp and level lookup
    always_comb
    begin
        if (s1_reg.step_request[7])
            clamp_step = 3'd0;
        else if (s1_reg.step_request > $signed(8'(mdsr_pkg::STEP_COUNT)))
            clamp_step = STEP_TOP;
        else
            clamp_step = s1_reg.step_request[2:0];

        case (clamp_step)
            3'd0:    level_sel = 10'd0;
            3'd1:    level_sel = cfg.level_one_duty;
            3'd2:    level_sel = cfg.level_two_duty;
            3'd3:    level_sel = cfg.level_three_duty;
            default: level_sel = cfg.level_four_duty;
        endcase
    end

    // Interval check and one ramp move toward the goal
    always_comb
    begin
        elapsed   = s1_reg.now_ms - last_time_reg;
        due       = ramp_on_reg && (elapsed >= 32'(cfg.ramp_interval));
        up_sum    = {1'b0, duty_reg} + {1'b0, cfg.ramp_increment};
        up_val    = (up_sum > {1'b0, goal_duty_reg}) ? goal_duty_reg : up_sum[9:0];
        down_amt  = (duty_reg > cfg.ramp_increment) ? cfg.ramp_increment : duty_reg;
        down_diff = duty_reg - down_amt;
        down_val  = (down_diff < goal_duty_reg) ? goal_duty_reg : down_diff;
        if (duty_reg < goal_duty_reg)
            ramp_val = up_val;
        else if (duty_reg > goal_duty_reg)
            ramp_val = down_val;
        else
            ramp_val = duty_reg;
    end

    // Next state per request
    always_comb
    begin
        duty_next      = duty_reg;
        goal_duty_next = goal_duty_reg;
        goal_step_next = goal_step_reg;
        ramp_on_next   = ramp_on_reg;
        last_time_next = last_time_reg;
        live_next      = live_reg;
        live_emit      = live_reg;
        emit           = 1'b0;

        case (mdsr_pkg::req_code_t'(s1_reg.req_type))
            mdsr_pkg::REQ_SET_STEP:
            begin
                emit           = 1'b1;
                goal_step_next = clamp_step;
                goal_duty_next = level_sel;
                if (clamp_step == 3'd0)
                begin
                    if (duty_reg == 10'd0)
                    begin
                        ramp_on_next = 1'b0;
                        live_next    = 1'b0;
                    end
                    else
                        ramp_on_next = 1'b1;
                end
                else
                begin
                    if (duty_reg == 10'd0)
                    begin
                        duty_next      = cfg.kick_duty;
                        live_next      = 1'b1;
                        last_time_next = s1_reg.now_ms;
                    end
                    ramp_on_next = (duty_next != level_sel);
                end
                live_emit = live_next;
            end
            mdsr_pkg::REQ_TICK:
            begin
                if (due)
                begin
                    emit           = 1'b1;
                    last_time_next = s1_reg.now_ms;
                    duty_next      = ramp_val;
                    live_next      = (ramp_val != 10'd0);
                    live_emit      = live_next;
                    ramp_on_next   = (ramp_val != goal_duty_reg);
                end
            end
            mdsr_pkg::REQ_STOP:
            begin
                emit           = 1'b1;
                goal_step_next = 3'd0;
                goal_duty_next = 10'd0;
                duty_next      = 10'd0;
                ramp_on_next   = 1'b0;
                live_next      = 1'b0;
                live_emit      = 1'b0;
            end
            default: ;
        endcase
    end

    // Result fields from the updated state
    always_comb
    begin
        pct_duty = (duty_next > DUTY_CAP) ? DUTY_CAP : duty_next;
        pct_in   = {1'b0, pct_duty} + ROUND_C;
        pct_prod = 19'(pct_in) * 19'(RECIP10);
        pct_quo  = pct_prod[18:11];
        pct_rem  = 12'(pct_in) - 12'(pct_quo) * DIV_C;
        pct_fix  = (pct_rem >= DIV_C) ? pct_quo + 8'd1 : pct_quo;

        rsp_next.enabled       = (goal_step_next != 3'd0) || (duty_next != 10'd0);
        rsp_next.step_now      = goal_step_next;
        rsp_next.duty_now      = duty_next;
        rsp_next.freq_report   = rsp_next.enabled ? cfg.pwm_frequency : 20'd0;
        rsp_next.pwm_percent   = live_emit ? pct_fix[6:0] : 7'd0;
        rsp_next.output_active = live_emit;
    end

    // Stage valid flags
    always_comb
    begin
        s1_valid_next = req_stall ? s1_valid_reg : req_valid;
        if (out_free)
            rsp_valid_next = advance && emit;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // Control and duty state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            duty_reg      <= 10'd0;
            goal_duty_reg <= 10'd0;
            goal_step_reg <= 3'd0;
            ramp_on_reg   <= 1'b0;
            last_time_reg <= 32'd0;
            live_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                duty_reg      <= duty_next;
                goal_duty_reg <= goal_duty_next;
                goal_step_reg <= goal_step_next;
                ramp_on_reg   <= ramp_on_next;
                last_time_reg <= last_time_next;
                live_reg      <= live_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_reg <= req;
        if (advance && emit)
            rsp_reg <= rsp_next;
    end

endmodule

FILE: rtl/mdsr_checker.sv
// ----------------------------------------------------------------------------
// mdsr_checker: port-level assertions for motor_duty_step_ramp
// Result transaction consistency, bound to the top level.
// ----------------------------------------------------------------------------
module mdsr_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input mdsr_pkg::rsp_t rsp
);

    // A stalled result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Step never above the top speed step
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.step_now <= 3'(mdsr_pkg::STEP_COUNT))
        else $error("step out of range");

    // Stopped output reports zero percent
    a_pct_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.output_active |-> rsp.pwm_percent == 7'd0)
        else $error("percent nonzero with output stopped");

    // Enabled follows step and duty, frequency follows enabled
    a_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.enabled == ((rsp.step_now != 3'd0) || (rsp.duty_now != 10'd0)))
                   && (rsp.enabled || (rsp.freq_report == 20'd0)))
        else $error("enabled or frequency inconsistent");

endmodule

bind motor_duty_step_ramp mdsr_checker u_mdsr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: sim/duty_ramp_checker.sv
// ----------------------------------------------------------------------------
// duty_ramp_checker: status predictor and scoreboard for motor_duty_step_ramp
// Watches the request, result and APB channels. It keeps a shadow of the
// registers and of the ramp state, predicts the status transaction that each
// accepted request produces, and compares results in order, field by field.
// APB reads are checked against the register shadow.
// ----------------------------------------------------------------------------
module duty_ramp_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  mdsr_pkg::req_t              req,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  mdsr_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdsr_pkg::ADDR_W-1:0] paddr,
    input  logic [mdsr_pkg::DATA_W-1:0] pwdata,
    input  logic [mdsr_pkg::DATA_W-1:0] prdata,
    input  logic                        pready,
    output int unsigned                 errors,
    output int unsigned                 pending,
    output int unsigned                 checked
);

    // Register shadow and ramp state
    mdsr_pkg::cfg_t shadow;
    logic [9:0]     duty;
    logic [9:0]     goal_duty;
    logic [2:0]     goal_step;
    logic           ramping;
    logic [31:0]    last_move_ms;
    logic           pwm_on;

    // Status transactions predicted but not yet seen
    mdsr_pkg::rsp_t status_due[$];

    // Duty level for a clamped step; anything above three uses level four
    function automatic logic [9:0] level_of(input logic [2:0] st);
        case (st)
            3'd0:    return 10'd0;
            3'd1:    return shadow.level_one_duty;
            3'd2:    return shadow.level_two_duty;
            3'd3:    return shadow.level_three_duty;
            default: return shadow.level_four_duty;
        endcase
    endfunction

    // Status as reported from the current state
    function automatic mdsr_pkg::rsp_t status_snapshot();
        mdsr_pkg::rsp_t s;
        int unsigned    d;
        s.enabled       = (goal_step != 3'd0) || (duty != 10'd0);
        s.step_now      = goal_step;
        s.duty_now      = duty;
        s.freq_report   = s.enabled ? shadow.pwm_frequency : 20'd0;
        d               = (duty > mdsr_pkg::DUTY_MAX) ? mdsr_pkg::DUTY_MAX : 32'(duty);
        s.pwm_percent   = pwm_on ? 7'((d + mdsr_pkg::PCT_ROUND) / mdsr_pkg::PCT_DIV) : 7'd0;
        s.output_active = pwm_on;
        return s;
    endfunction

    // Apply one request to the ramp state; returns 1 when a status is produced
    function automatic bit predict_status(input mdsr_pkg::req_t r,
                                          output mdsr_pkg::rsp_t s);
        int          req_step;
        logic [2:0]  cs;
        logic [10:0] sum;
        logic [9:0]  dec;
        logic [31:0] elapsed;
        s = '0;
        case (mdsr_pkg::req_code_t'(r.req_type))
            mdsr_pkg::REQ_SET_STEP:
            begin
                req_step = $signed(r.step_request);
                if (req_step < 0)
                    cs = 3'd0;
                else if (req_step > int'(mdsr_pkg::STEP_COUNT))
                    cs = 3'(mdsr_pkg::STEP_COUNT);
                else
                    cs = 3'(req_step);
                goal_step = cs;
                if (cs == 3'd0)
                begin
                    goal_duty = 10'd0;
                    if (duty == 10'd0)
                    begin
                        ramping = 1'b0;
                        pwm_on  = 1'b0;
                    end
                    else
                    begin
                        ramping = 1'b1;
                    end
                end
                else
                begin
                    goal_duty = level_of(cs);
                    // kickstart from standstill
                    if (duty == 10'd0)
                    begin
                        duty         = shadow.kick_duty;
                        pwm_on       = 1'b1;
                        last_move_ms = r.now_ms;
                    end
                    ramping = (duty != goal_duty);
                end
                s = status_snapshot();
                return 1'b1;
            end
            mdsr_pkg::REQ_TICK:
            begin
                if (!ramping)
                    return 1'b0;
                // unsigned wrap on the millisecond counter
                elapsed = r.now_ms - last_move_ms;
                if (elapsed < 32'(shadow.ramp_interval))
                    return 1'b0;
                last_move_ms = r.now_ms;
                if (duty < goal_duty)
                begin
                    sum  = 11'(duty) + 11'(shadow.ramp_increment);
                    duty = (sum > 11'(goal_duty)) ? goal_duty : sum[9:0];
                end
                else if (duty > goal_duty)
                begin
                    dec  = (duty > shadow.ramp_increment) ? shadow.ramp_increment : duty;
                    dec  = duty - dec;
                    duty = (dec < goal_duty) ? goal_duty : dec;
                end
                pwm_on = (duty != 10'd0);
                s = status_snapshot();
                // ramp finished: stop, and drop the output when at zero
                if (duty == goal_duty)
                begin
                    ramping = 1'b0;
                    if (duty == 10'd0)
                        pwm_on = 1'b0;
                end
                return 1'b1;
            end
            mdsr_pkg::REQ_STOP:
            begin
                goal_step = 3'd0;
                goal_duty = 10'd0;
                duty      = 10'd0;
                ramping   = 1'b0;
                pwm_on    = 1'b0;
                s = status_snapshot();
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Register write into the shadow
    function automatic void write_shadow(input mdsr_pkg::reg_idx_t idx,
                                         input logic [mdsr_pkg::DATA_W-1:0] v);
        case (idx)
            mdsr_pkg::REG_LEVEL_ONE:   shadow.level_one_duty   = v[9:0];
            mdsr_pkg::REG_LEVEL_TWO:   shadow.level_two_duty   = v[9:0];
            mdsr_pkg::REG_LEVEL_THREE: shadow.level_three_duty = v[9:0];
            mdsr_pkg::REG_LEVEL_FOUR:  shadow.level_four_duty  = v[9:0];
            mdsr_pkg::REG_KICK:        shadow.kick_duty        = v[9:0];
            mdsr_pkg::REG_INTERVAL:    shadow.ramp_interval    = v[15:0];
            mdsr_pkg::REG_INCREMENT:   shadow.ramp_increment   = v[9:0];
            default:                   shadow.pwm_frequency    = v[19:0];
        endcase
    endfunction

    // Register value as an APB read should return it
    function automatic logic [mdsr_pkg::DATA_W-1:0] reg_readback(
        input mdsr_pkg::reg_idx_t idx);
        logic [mdsr_pkg::DATA_W-1:0] v;
        v = '0;
        case (idx)
            mdsr_pkg::REG_LEVEL_ONE:   v = mdsr_pkg::DATA_W'(shadow.level_one_duty);
            mdsr_pkg::REG_LEVEL_TWO:   v = mdsr_pkg::DATA_W'(shadow.level_two_duty);
            mdsr_pkg::REG_LEVEL_THREE: v = mdsr_pkg::DATA_W'(shadow.level_three_duty);
            mdsr_pkg::REG_LEVEL_FOUR:  v = mdsr_pkg::DATA_W'(shadow.level_four_duty);
            mdsr_pkg::REG_KICK:        v = mdsr_pkg::DATA_W'(shadow.kick_duty);
            mdsr_pkg::REG_INTERVAL:    v = mdsr_pkg::DATA_W'(shadow.ramp_interval);
            mdsr_pkg::REG_INCREMENT:   v = mdsr_pkg::DATA_W'(shadow.ramp_increment);
            default:                   v = mdsr_pkg::DATA_W'(shadow.pwm_frequency);
        endcase
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        mdsr_pkg::reg_idx_t idx;
        mdsr_pkg::rsp_t     fresh;
        mdsr_pkg::rsp_t     want;
        if (!rst_n)
        begin
            shadow.level_one_duty   = 10'd250;
            shadow.level_two_duty   = 10'd500;
            shadow.level_three_duty = 10'd750;
            shadow.level_four_duty  = 10'd1000;
            shadow.kick_duty        = 10'd350;
            shadow.ramp_interval    = 16'd20;
            shadow.ramp_increment   = 10'd10;
            shadow.pwm_frequency    = 20'd20000;
            duty         = '0;
            goal_duty    = '0;
            goal_step    = '0;
            ramping      = 1'b0;
            last_move_ms = '0;
            pwm_on       = 1'b0;
            status_due.delete();
            errors  = 0;
            checked = 0;
            pending <= 0;
        end
        else
        begin
            // APB access phase
            if (psel && penable && pready)
            begin
                idx = mdsr_pkg::reg_idx_t'(paddr[mdsr_pkg::ADDR_W-1:2]);
                if (pwrite)
                    write_shadow(idx, pwdata);
                else if (prdata !== reg_readback(idx))
                begin
                    errors++;
                    $display("%0t: register %s readback mismatch, expected %0d, got %0d",
                             $time, idx.name(), reg_readback(idx), prdata);
                end
            end
            // accepted request transaction
            if (req_valid && !req_stall)
            begin
                if (predict_status(req, fresh))
                    status_due.push_back(fresh);
            end
            // accepted status transaction
            if (rsp_valid && !rsp_stall)
            begin
                if (status_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: status with none expected, got %h", $time, rsp);
                end
                else
                begin
                    want = status_due.pop_front();
                    compare_field("enabled",       32'(want.enabled),
                                  32'(rsp.enabled));
                    compare_field("step_now",      32'(want.step_now),
                                  32'(rsp.step_now));
                    compare_field("duty_now",      32'(want.duty_now),
                                  32'(rsp.duty_now));
                    compare_field("freq_report",   32'(want.freq_report),
                                  32'(rsp.freq_report));
                    compare_field("pwm_percent",   32'(want.pwm_percent),
                                  32'(rsp.pwm_percent));
                    compare_field("output_active", 32'(want.output_active),
                                  32'(rsp.output_active));
                    checked++;
                end
            end
            pending <= status_due.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for motor_duty_step_ramp
// Directed set-step, tick and stop requests cover clamping, kickstart, time
// wrap, zero kick and increment and levels above the duty ceiling; random
// phases then run ramp sequences under several register settings and
// idling patterns, including a long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_stall;
    mdsr_pkg::req_t              req;
    logic                        rsp_valid;
    logic                        rsp_stall;
    mdsr_pkg::rsp_t              rsp;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [mdsr_pkg::ADDR_W-1:0] paddr;
    logic [mdsr_pkg::DATA_W-1:0] pwdata;
    logic [mdsr_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    int unsigned       errors;
    int unsigned       pending;
    int unsigned       checked;

    // Stimulus control
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    bit                hold_request;
    mdsr_pkg::cfg_t    cur_cfg;
    logic [31:0]       clock_ms;
    int unsigned       n_set;
    int unsigned       n_tick;
    int unsigned       n_stop;
    int unsigned       n_drop;
    int unsigned       n_settings;

    motor_duty_step_ramp dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    duty_ramp_checker status_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result receiver: random stalls, or a long hold-off when requested
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic mdsr_pkg::cfg_t settings(input int unsigned l1, input int unsigned l2,
                                                input int unsigned l3, input int unsigned l4,
                                                input int unsigned kick, input int unsigned intv,
                                                input int unsigned inc, input int unsigned freq);
        mdsr_pkg::cfg_t c;
        c.level_one_duty   = 10'(l1);
        c.level_two_duty   = 10'(l2);
        c.level_three_duty = 10'(l3);
        c.level_four_duty  = 10'(l4);
        c.kick_duty        = 10'(kick);
        c.ramp_interval    = 16'(intv);
        c.ramp_increment   = 10'(inc);
        c.pwm_frequency    = 20'(freq);
        return c;
    endfunction

    // Mostly in-range duty, sometimes above the ceiling
    function automatic logic [9:0] random_duty();
        return ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                        : 10'($urandom_range(1000));
    endfunction

    function automatic mdsr_pkg::cfg_t random_settings();
        mdsr_pkg::cfg_t c;
        c.level_one_duty   = random_duty();
        c.level_two_duty   = random_duty();
        c.level_three_duty = random_duty();
        c.level_four_duty  = random_duty();
        c.kick_duty        = random_duty();
        c.ramp_interval    = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                      : 16'($urandom_range(40));
        c.ramp_increment   = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                                      : 10'($urandom_range(200, 1));
        c.pwm_frequency    = 20'($urandom_range(20'hFFFFF));
        return c;
    endfunction

    function automatic mdsr_pkg::req_t make_req(input mdsr_pkg::req_code_t code,
                                                input logic [7:0] st,
                                                input logic [31:0] ms);
        mdsr_pkg::req_t r;
        r.req_type     = code;
        r.step_request = st;
        r.now_ms       = ms;
        return r;
    endfunction

    // Random request; ticks advance a running millisecond clock
    function automatic mdsr_pkg::req_t random_request();
        mdsr_pkg::req_t r;
        int unsigned    pick;
        pick = $urandom_range(99);
        r.step_request = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(6) - 1);
        if (pick < 18)
        begin
            r.req_type = mdsr_pkg::REQ_SET_STEP;
            r.now_ms   = clock_ms;
        end
        else if (pick < 88)
        begin
            r.req_type = mdsr_pkg::REQ_TICK;
            if ($urandom_range(99) < 3)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(2 * cur_cfg.ramp_interval + 2);
            r.now_ms = clock_ms;
        end
        else
        begin
            r.req_type = (pick < 95) ? mdsr_pkg::REQ_STOP : mdsr_pkg::REQ_NONE;
            r.now_ms   = $urandom();
        end
        return r;
    endfunction

    // One APB transfer: setup, access, then return to idle
    task automatic apb_access(input bit wr, input mdsr_pkg::reg_idx_t idx,
                              input logic [mdsr_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write every register, then read all of them back
    task automatic load_settings(input mdsr_pkg::cfg_t c);
        apb_access(1'b1, mdsr_pkg::REG_LEVEL_ONE,   mdsr_pkg::DATA_W'(c.level_one_duty));
        apb_access(1'b1, mdsr_pkg::REG_LEVEL_TWO,   mdsr_pkg::DATA_W'(c.level_two_duty));
        apb_access(1'b1, mdsr_pkg::REG_LEVEL_THREE, mdsr_pkg::DATA_W'(c.level_three_duty));
        apb_access(1'b1, mdsr_pkg::REG_LEVEL_FOUR,  mdsr_pkg::DATA_W'(c.level_four_duty));
        apb_access(1'b1, mdsr_pkg::REG_KICK,        mdsr_pkg::DATA_W'(c.kick_duty));
        apb_access(1'b1, mdsr_pkg::REG_INTERVAL,    mdsr_pkg::DATA_W'(c.ramp_interval));
        apb_access(1'b1, mdsr_pkg::REG_INCREMENT,   mdsr_pkg::DATA_W'(c.ramp_increment));
        apb_access(1'b1, mdsr_pkg::REG_FREQUENCY,   mdsr_pkg::DATA_W'(c.pwm_frequency));
        for (int i = 0; i < 8; i++)
            apb_access(1'b0, mdsr_pkg::reg_idx_t'(i), '0);
        cur_cfg = c;
        n_settings++;
    endtask

    // Offer one request transaction, then maybe idle
    task automatic send_req(input mdsr_pkg::req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        case (mdsr_pkg::req_code_t'(r.req_type))
            mdsr_pkg::REQ_SET_STEP: n_set++;
            mdsr_pkg::REQ_TICK:     n_tick++;
            mdsr_pkg::REQ_STOP:     n_stop++;
            default:                n_drop++;
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Wait until every expected status arrived and the pipeline is empty
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Main stimulus
    initial
    begin : stimulus
        mdsr_pkg::req_t r;
        int unsigned    sent;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        clock_ms       = '0;
        n_set          = 0;
        n_tick         = 0;
        n_stop         = 0;
        n_drop         = 0;
        n_settings     = 0;
        cur_cfg        = settings(250, 500, 750, 1000, 350, 20, 10, 20000);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd5));         // ramp off
        send_req(make_req(mdsr_pkg::REQ_NONE,     8'h7F, 32'hFFFF_FFFF)); // dropped code
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd2,  32'd100));       // kickstart
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd110));       // interval not up
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd120));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'h7F, 32'd130));       // clamp to top
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'h80, 32'd140));       // negative step
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'hFFFF_FFF0));
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd4));         // time wrap
        send_req(make_req(mdsr_pkg::REQ_STOP,     8'hFF, 32'd0));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd0,  32'd7));         // off while stopped
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd1,  32'd50));        // kick above goal
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd70));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd3,  32'd71));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd5,  32'd72));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'hFF, 32'd73));
        send_req(make_req(mdsr_pkg::REQ_STOP,     8'h80, 32'hAAAA_AAAA));
        settle();

        // Zero kick, zero increment, zero interval, levels above the ceiling
        load_settings(settings(1023, 0, 1001, 1023, 0, 0, 0, 20'hFFFFF));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd1,  32'd0));
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd0));
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd0));
        send_req(make_req(mdsr_pkg::REQ_STOP,     8'd0,  32'd0));
        settle();

        // Full kick, full-range step down to a zero level
        load_settings(settings(0, 0, 1000, 1023, 1023, 0, 1023, 0));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd4,  32'd9));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd1,  32'd9));
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd9));
        send_req(make_req(mdsr_pkg::REQ_TICK,     8'd0,  32'd9));
        send_req(make_req(mdsr_pkg::REQ_SET_STEP, 8'd2,  32'd9));
        settle();

        // Random phases: settings and idling pattern change per phase
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 1)
                load_settings(settings(1023, 1023, 1023, 1023, 1023, 65535, 1023, 20'hFFFFF));
            else if (phase == 5)
                load_settings(settings(0, 0, 0, 0, 0, 0, 0, 0));
            else
                load_settings(random_settings());
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            // long hold-off with the sender still pushing: input backs up
            if (phase == 0)
            begin
                hold_request = 1'b1;
                repeat (30)
                    send_req(make_req(mdsr_pkg::REQ_SET_STEP,
                                      8'($urandom_range(6) - 1), clock_ms));
            end
            sent = 0;
            while (sent < 125)
            begin
                r = random_request();
                send_req(r);
                if (r.req_type != mdsr_pkg::REQ_NONE)
                    sent++;
            end
            settle();
        end

        $display("covered %0d set-step, %0d tick, %0d stop and %0d dropped requests,",
                 n_set, n_tick, n_stop, n_drop);
        $display("%0d statuses compared over %0d register loads with a long output hold-off",
                 checked, n_settings);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #3000000;
        $display("timeout with %0d statuses outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: motor_duty_step_ramp.f
rtl/mdsr_pkg.sv
rtl/mdsr_regs.sv
rtl/mdsr_core.sv
rtl/motor_duty_step_ramp.sv
rtl/mdsr_checker.sv
sim/duty_ramp_checker.sv
sim/testbench.sv
